// ===== sv/lbc80_pkg.sv =====
// Package for the 80-bit-key lightweight block cipher pipeline.
// Holds the substitution box, the layer functions and the register indexes.
// Used by lightweight_block_cipher_80bit_key; depends on nothing.
package lbc80_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 80;
    localparam int CNT_W   = 5;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [CNT_W-1:0]   t_cnt;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_UPPER = 1'b0,
        REG_KEY_LOWER = 1'b1
    } t_reg_idx;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit j moves to j/4 + 16*(j mod 4): pure wiring
    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int j = 0; j < BLOCK_W; j++) begin
            r[(j / 4) + (BLOCK_W / 4) * (j % 4)] = s[j];
        end
        return r;
    endfunction

    function automatic t_block round_fn(input t_block s, input t_key k);
        return perm_layer(sub_layer(s ^ k[KEY_W-1 -: BLOCK_W]));
    endfunction

endpackage

// ===== sv/lightweight_block_cipher_80bit_key.sv =====
// Top level of the 80-bit-key lightweight block cipher: unrolled round pipeline.
// One register stage per round plus an output register for the final key addition.
// Depends on lbc80_pkg.
//
//  channel   | dir | fields (tdata, low bit up)  | handshake
//  ----------+-----+-----------------------------+--------------------------
//  s_axis    | in  | plaintext[63:0]             | s_axis_tvalid/tready
//  m_axis    | out | ciphertext[63:0]            | m_axis_tvalid/tready
//  cfg       | in  | 0: key_upper, 1: key_lower  | i_cfg_we, no wait
//
// Each stage computes one round, then the final key XOR goes into the output register.
// One request per cycle is taken sustained while the output is not stalled.
// Each stage carries its own round key, so the schedule advances with the block.
// Synchronous active-low reset clears the valid bits and the configured key registers.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
module lightweight_block_cipher_80bit_key
    import lbc80_pkg::*;
#(
    parameter int ROUND_COUNT  = 31,
    parameter int KEY_ROTATION = 61
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] plaintext
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] ciphertext
);

    function automatic t_key key_update(input t_key k, input t_cnt cnt);
        t_key r;
        r = (k << KEY_ROTATION) | (k >> (KEY_W - KEY_ROTATION));
        r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ cnt;
        return r;
    endfunction

    logic [15:0] r_key_upper;
    logic [63:0] r_key_lower;

    t_block r_state [ROUND_COUNT];
    t_key   r_key   [ROUND_COUNT];
    logic   r_vld   [ROUND_COUNT];

    t_block r_out;
    logic   r_out_vld;
    logic   adv;
    t_key   cfg_key;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_key       = {r_key_upper, r_key_lower};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_KEY_UPPER: r_key_upper <= i_cfg_data[15:0];
                REG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // first round straight from the input and the configured key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= s_axis_tvalid;
        end
        if (adv) begin
            r_state[0] <= round_fn(s_axis_tdata, cfg_key);
            r_key[0]   <= key_update(cfg_key, t_cnt'(1));
        end
    end

    for (genvar g = 1; g < ROUND_COUNT; g++) begin : g_round
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (adv) begin
                r_vld[g] <= r_vld[g-1];
            end
            if (adv) begin
                r_state[g] <= round_fn(r_state[g-1], r_key[g-1]);
                r_key[g]   <= key_update(r_key[g-1], t_cnt'(g + 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[ROUND_COUNT-1];
        end
        if (adv) begin
            r_out <= r_state[ROUND_COUNT-1] ^ r_key[ROUND_COUNT-1][KEY_W-1 -: BLOCK_W];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

// ===== sv/lbc80_checker.sv =====
// Port-level checker for the cipher pipeline, bound to the top level.
// Watches the stream handshakes only; depends on nothing else.
module lbc80_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // input side only backs up when a result is waiting and not taken
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |-> s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind lightweight_block_cipher_80bit_key lbc80_checker u_lbc80_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
